### design/national_id_check_and_age_gate_unit_assert.svh
// assertion macros for the identity number check unit
`ifndef NATIONAL_ID_CHECK_AND_AGE_GATE_UNIT_ASSERT_SVH
`define NATIONAL_ID_CHECK_AND_AGE_GATE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define NIDAG_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("nidag assertion failed");
// next-cycle implication
`define NIDAG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("nidag assertion failed");
`else
`define NIDAG_ASSERT_IMPLIES(lbl, ck, rs, ante, cons)
`define NIDAG_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

### design/nidag_pkg.sv
// types, constants and helper functions of the identity number check unit
`default_nettype none

package nidag_pkg;

  // character codes
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_XU = 8'h58;
  localparam logic [7:0] CHAR_XL = 8'h78;

  // string positions
  localparam logic [4:0] LEN15_LAST = 5'd14;
  localparam logic [4:0] LEN18_LAST = 5'd17;
  localparam logic [4:0] SUM_LEN    = 5'd17;
  localparam logic [4:0] COUNT_SAT  = 5'd19;
  localparam logic [4:0] DATE_FIRST = 5'd6;
  localparam int unsigned DATE_DEPTH = 8;

  // configuration register indexes
  localparam logic [1:0] REG_YEAR_OFFSET = 2'd0;
  localparam logic [1:0] REG_MONTH       = 2'd1;
  localparam logic [1:0] REG_DAY         = 2'd2;

  localparam logic [7:0] YEAR_OFFSET_RESET = 8'd124;
  localparam logic [3:0] MONTH_RESET       = 4'd1;
  localparam logic [4:0] DAY_RESET         = 5'd1;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [7:0] year_off;
    logic [3:0] month;
    logic [4:0] day;
  } cur_date_t;

  // running state of the string being scanned
  typedef struct packed {
    logic [4:0] pos;
    logic       digits_ok;
    logic [3:0] sum_mod;
  } scan_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

  function automatic logic [3:0] weight(input logic [4:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0:    w = 4'd7;
      5'd1:    w = 4'd9;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd8;
      5'd5:    w = 4'd4;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd1;
      5'd8:    w = 4'd6;
      5'd9:    w = 4'd3;
      5'd10:   w = 4'd7;
      5'd11:   w = 4'd9;
      5'd12:   w = 4'd10;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd8;
      5'd15:   w = 4'd4;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // (s + dg * w) mod 11, s below 11; reciprocal multiply holds for sums up to 100
  function automatic logic [3:0] mod11_step(input logic [3:0] s, input digit_t dg,
                                            input logic [3:0] w);
    logic [6:0]  t;
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    t    = 7'(s) + 7'(dg) * 7'(w);
    prod = 15'(t) * 15'd187;
    q    = prod[14:11];
    r    = t - 7'(q) * 7'd11;
    return r[3:0];
  endfunction

  // expected check character for a sum residue
  function automatic logic [7:0] check_char(input logic [3:0] s);
    logic [7:0] c;
    case (s)
      4'd0:    c = CHAR_0 + 8'd1;
      4'd1:    c = CHAR_0;
      4'd2:    c = CHAR_XU;
      4'd3:    c = CHAR_0 + 8'd9;
      4'd4:    c = CHAR_0 + 8'd8;
      4'd5:    c = CHAR_0 + 8'd7;
      4'd6:    c = CHAR_0 + 8'd6;
      4'd7:    c = CHAR_0 + 8'd5;
      4'd8:    c = CHAR_0 + 8'd4;
      4'd9:    c = CHAR_0 + 8'd3;
      4'd10:   c = CHAR_0 + 8'd2;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] two_dig(input digit_t hi, input digit_t lo);
    return 7'(hi) * 7'd10 + 7'(lo);
  endfunction

endpackage

`default_nettype wire

### design/nidag_if.sv
// handshake channels of the identity number check unit
`default_nettype none

interface nidag_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

interface nidag_res_if;
  logic valid;
  logic ready;
  logic valid_res;
  logic adult;
  modport source (output valid, valid_res, adult, input ready);
  modport sink (input valid, valid_res, adult, output ready);
endinterface

interface nidag_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/nidag_eval.sv
// end-of-string evaluation: format, date, check character and age test
`default_nettype none

module nidag_eval import nidag_pkg::*; (
  input  scan_state_t                     scan,
  input  logic [7:0]                      char_code,
  input  logic [DATE_DEPTH-1:0][3:0]      date_dig,
  input  cur_date_t                       cur,
  output logic                            valid_res,
  output logic                            adult
);

  logic       all_dig;
  logic       is15;
  logic       is18;
  logic [6:0] hi2;
  logic [6:0] lo2;
  logic [6:0] m15;
  logic [6:0] d15;
  logic [6:0] m18;
  logic [6:0] d18;
  logic       yr18_ok;
  logic [7:0] want;
  logic       chk_ok;
  logic [7:0] by;
  logic [6:0] bm;
  logic [6:0] bd;
  logic       date_ok;
  logic [8:0] target;
  logic [8:0] cy;
  logic [6:0] cm;
  logic [6:0] cd;

  always_comb begin
    // the final character still counts toward the digit check below position 17
    all_dig = scan.digits_ok && ((scan.pos >= SUM_LEN) || is_digit(char_code));
    is15    = (scan.pos == LEN15_LAST);
    is18    = (scan.pos == LEN18_LAST);

    hi2 = two_dig(date_dig[0], date_dig[1]);
    lo2 = two_dig(date_dig[2], date_dig[3]);
    m15 = lo2;
    d15 = two_dig(date_dig[4], date_dig[5]);
    m18 = d15;
    d18 = two_dig(date_dig[6], date_dig[7]);

    // four-digit year 1900..2020
    yr18_ok = (hi2 == 7'd19) || ((hi2 == 7'd20) && (lo2 <= 7'd20));

    want   = check_char(scan.sum_mod);
    chk_ok = (want == CHAR_XU) ? ((char_code == CHAR_XU) || (char_code == CHAR_XL))
                               : (char_code == want);

    if (is18) begin
      by = (hi2 == 7'd19) ? 8'(lo2) : 8'(lo2) + 8'd100;
      bm = m18;
      bd = d18;
    end else begin
      by = 8'(hi2);
      bm = m15;
      bd = d15;
    end

    date_ok = (bm >= 7'd1) && (bm <= 7'd12) && (bd >= 7'd1) && (bd <= 7'd31);

    valid_res = all_dig && date_ok && (is15 || (is18 && yr18_ok && chk_ok));

    target = 9'(by) + 9'd18;
    cy     = 9'(cur.year_off);
    cm     = 7'(cur.month);
    cd     = 7'(cur.day);
    adult  = valid_res &&
             ((cy > target) || ((cy == target) && ((cm > bm) || ((cm == bm) && (cd >= bd)))));
  end

endmodule

`default_nettype wire

### design/national_id_check_and_age_gate_unit.sv
// top level of the identity number check and age gate unit
`default_nettype none

// Checks an identity number that arrives one character per transfer on
// char_in, with last_char marking the final character, and returns one
// result on res_out for each string: valid_res (15-digit or 18-digit form,
// birth date and, for 18 digits, the mod-11 check character all pass) and
// adult (holder is 18 or older on the date held in the configuration
// registers; always 0 for an invalid number). Throughput is one character
// per clock: each character updates the running scan state (position,
// digit flag, weighted sum mod 11, birth-date digits) in the cycle it is
// taken, and on the final character the evaluation logic fills the result
// register, so the result is offered the cycle after the last transfer.
// char_in.ready is low only while a result sits in the result register and
// res_out.ready is low. Configuration writes (index 0 year offset from 1900,
// 1 month, 2 day) are always taken and belong in idle periods.

module national_id_check_and_age_gate_unit import nidag_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  nidag_char_if.sink     char_in,
  nidag_res_if.source    res_out,
  nidag_cfg_if.sink      cfg
);

`include "national_id_check_and_age_gate_unit_assert.svh"

  // running scan state
  scan_state_t                scan;
  scan_state_t                scan_next;
  logic [DATE_DEPTH-1:0][3:0] date_dig;

  // configured current date
  cur_date_t                  cur;

  // result register
  logic res_valid;
  logic res_valid_res;
  logic res_adult;

  logic char_xfer;
  logic eval_valid;
  logic eval_adult;
  logic c_is_digit;

  assign char_in.ready = !res_valid || res_out.ready;
  assign char_xfer     = char_in.valid && char_in.ready;
  assign c_is_digit    = is_digit(char_in.char_code);

  assign cfg.ready = 1'b1;

  assign res_out.valid     = res_valid;
  assign res_out.valid_res = res_valid_res;
  assign res_out.adult     = res_adult;

  nidag_eval u_eval (
    .scan      (scan),
    .char_code (char_in.char_code),
    .date_dig  (date_dig),
    .cur       (cur),
    .valid_res (eval_valid),
    .adult     (eval_adult)
  );

  // next scan state for one accepted character
  always_comb begin
    scan_next = scan;
    if (scan.pos < SUM_LEN) begin
      if (c_is_digit) begin
        scan_next.sum_mod = mod11_step(scan.sum_mod, char_in.char_code[3:0],
                                       weight(scan.pos));
      end else begin
        scan_next.digits_ok = 1'b0;
      end
    end
    if (char_in.last_char) begin
      // string done, start over
      scan_next.pos       = '0;
      scan_next.sum_mod   = '0;
      scan_next.digits_ok = 1'b1;
    end else if (scan.pos < COUNT_SAT) begin
      scan_next.pos = scan.pos + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan.pos       <= '0;
      scan.sum_mod   <= '0;
      scan.digits_ok <= 1'b1;
    end else if (char_xfer) begin
      scan <= scan_next;
    end
  end

  // birth-date digits, positions 6..13; only the low nibble matters for digits
  always_ff @(posedge clk) begin
    if (char_xfer) begin
      for (int i = 0; i < DATE_DEPTH; i++) begin
        if (scan.pos == DATE_FIRST + 5'(i)) begin
          date_dig[i] <= char_in.char_code[3:0];
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.year_off <= YEAR_OFFSET_RESET;
      cur.month    <= MONTH_RESET;
      cur.day      <= DAY_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_YEAR_OFFSET: cur.year_off <= cfg.data;
        REG_MONTH:       cur.month    <= cfg.data[3:0];
        REG_DAY:         cur.day      <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // result register: loaded on the final character, freed by the sink
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (char_xfer && char_in.last_char) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_xfer && char_in.last_char) begin
      res_valid_res <= eval_valid;
      res_adult     <= eval_adult;
    end
  end

  // checks
  `NIDAG_ASSERT_IMPLIES(a_adult_needs_valid, clk, rst, res_valid && res_adult, res_valid_res)
  `NIDAG_ASSERT_IMPLIES(a_pos_saturates, clk, rst, 1'b1, scan.pos <= COUNT_SAT)
  `NIDAG_ASSERT_NEXT(a_last_restarts, clk, rst, char_xfer && char_in.last_char, res_valid && (scan.pos == 5'd0) && scan.digits_ok && (scan.sum_mod == 4'd0))
  `NIDAG_ASSERT_IMPLIES(a_sum_residue, clk, rst, 1'b1, scan.sum_mod <= 4'd10)

endmodule

`default_nettype wire
